FILE: design/assert_macros.svh
// Assertion helper macros shared by the RTL files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property check, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: design/psc_pkg.sv
// Shared widths, constants and stage payload types for the PID step block.
// No dependencies.
package psc_pkg;

    // field and intermediate widths
    localparam int ERR_W     = 16;               // error, Q3.12
    localparam int GAIN_W    = 24;               // gains, Q7.16
    localparam int INTEG_W   = 14;               // clamped integral, +/-4096 fits
    localparam int DERIV_W   = 17;               // exact error difference
    localparam int PROD_E_W  = GAIN_W + ERR_W;   // Kp*e
    localparam int PROD_I_W  = GAIN_W + INTEG_W; // Ki*i
    localparam int PROD_D_W  = GAIN_W + DERIV_W; // Kd*d
    localparam int SUM_W     = PROD_D_W + 2;     // sum of three products
    localparam int OUT_SHIFT = 14;
    localparam int SHIFT_W   = SUM_W - OUT_SHIFT;
    localparam int DRIVE_W   = 16;               // drive, Q1.14
    localparam int CFG_IDX_W = 2;

    localparam int ONE_Q12 = 4096;
    localparam int ONE_Q14 = 16384;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 2'd2;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop;
        logic signed [GAIN_W-1:0] integ;
        logic signed [GAIN_W-1:0] deriv;
    } t_gains;

    // controller terms for one sample
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
    } t_terms;

    // gain products for one sample
    typedef struct packed {
        logic signed [PROD_E_W-1:0] prod_prop;
        logic signed [PROD_I_W-1:0] prod_integ;
        logic signed [PROD_D_W-1:0] prod_deriv;
    } t_prods;

endpackage

FILE: design/pid_step_with_clamps.sv
// PID step with clamped integral and clamped output, three-stage pipeline.
// A sample's drive value is valid once it has passed the term, product and output
// registers. Throughput: one transaction per cycle while i_out_ready holds; each stage
// holds one item, set by the registered term, product and output stages. Reset
// (synchronous, active low) clears gains, integral, previous error and all stage valids.
// Depends on psc_pkg, psc_update, psc_mult, psc_limit and assert_macros.svh.
`include "assert_macros.svh"

module pid_step_with_clamps (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration write port
    input  logic                                     i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [psc_pkg::GAIN_W-1:0]               i_cfg_data,
    // sample channel
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic signed [psc_pkg::ERR_W-1:0]         i_cross_error,
    // result channel
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [psc_pkg::DRIVE_W-1:0]       o_drive,
    output logic                                     o_clamped
);

    localparam logic signed [psc_pkg::INTEG_W-1:0] INTEG_LIM =
        psc_pkg::INTEG_W'(psc_pkg::ONE_Q12);
    localparam logic signed [psc_pkg::DRIVE_W-1:0] DRIVE_LIM =
        psc_pkg::DRIVE_W'(psc_pkg::ONE_Q14);

    psc_pkg::t_gains r_gains;
    psc_pkg::t_terms w_terms;
    psc_pkg::t_prods w_prods;
    logic            w_terms_valid;
    logic            w_mult_ready;
    logic            w_prods_valid;
    logic            w_limit_ready;
    logic            w_out_clamped;
    logic            w_drive_at_lim;
    logic            w_integ_in_lim;

    // gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                psc_pkg::CFG_GAIN_PROP:  r_gains.prop  <= i_cfg_data;
                psc_pkg::CFG_GAIN_INTEG: r_gains.integ <= i_cfg_data;
                psc_pkg::CFG_GAIN_DERIV: r_gains.deriv <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    psc_update u_update (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_cross_error (i_cross_error),
        .i_ready       (w_mult_ready),
        .o_valid       (w_terms_valid),
        .o_terms       (w_terms)
    );

    psc_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_terms_valid),
        .o_ready (w_mult_ready),
        .i_terms (w_terms),
        .i_gains (r_gains),
        .i_ready (w_limit_ready),
        .o_valid (w_prods_valid),
        .o_prods (w_prods)
    );

    psc_limit u_limit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_prods_valid),
        .o_ready   (w_limit_ready),
        .i_prods   (w_prods),
        .i_ready   (i_out_ready),
        .o_valid   (o_out_valid),
        .o_drive   (o_drive),
        .o_clamped (o_clamped)
    );

    // check terms
    assign w_out_clamped  = o_out_valid && o_clamped;
    assign w_drive_at_lim = (o_drive == DRIVE_LIM) || (o_drive == -DRIVE_LIM);
    assign w_integ_in_lim = (w_terms.integ <= INTEG_LIM) && (w_terms.integ >= -INTEG_LIM);

    // checks
    `ASSERT_CLK(a_clamp_at_limit, i_clk, i_rst_n, w_out_clamped |-> w_drive_at_lim, "drive off limit")
    `ASSERT_CLK(a_integ_range, i_clk, i_rst_n, w_terms_valid |-> w_integ_in_lim, "integral out of range")
    `ASSERT_CLK(a_empty_stage_ready, i_clk, i_rst_n, !w_terms_valid |-> o_in_ready, "stalled when empty")

endmodule

FILE: design/psc_update.sv
// First stage: error negation, clamped integral and derivative, with loop state.
// Depends on psc_pkg.
module psc_update (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [psc_pkg::ERR_W-1:0]     i_cross_error,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output psc_pkg::t_terms                      o_terms
);

    localparam logic signed [psc_pkg::ERR_W-1:0] ERR_MIN = {1'b1, {(psc_pkg::ERR_W-1){1'b0}}};
    localparam logic signed [psc_pkg::ERR_W-1:0] ERR_MAX = {1'b0, {(psc_pkg::ERR_W-1){1'b1}}};
    localparam logic signed [psc_pkg::DERIV_W-1:0] INTEG_MAX =
        psc_pkg::DERIV_W'(psc_pkg::ONE_Q12);
    localparam logic signed [psc_pkg::DERIV_W-1:0] INTEG_MIN = -INTEG_MAX;

    logic signed [psc_pkg::INTEG_W-1:0] r_integ;
    logic signed [psc_pkg::ERR_W-1:0]   r_last_err;
    logic                               r_valid;
    psc_pkg::t_terms                    r_terms;

    logic                               w_accept;
    logic signed [psc_pkg::ERR_W-1:0]   w_err;
    logic signed [psc_pkg::DERIV_W-1:0] w_integ_raw;
    logic signed [psc_pkg::DERIV_W-1:0] w_integ_sat;
    psc_pkg::t_terms                    n_terms;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // negate the sample, most negative code saturates to the positive max
    assign w_err = (i_cross_error == ERR_MIN) ? ERR_MAX : -i_cross_error;

    // integral add and clamp to +/- one
    always_comb begin
        w_integ_raw = psc_pkg::DERIV_W'(r_integ) + psc_pkg::DERIV_W'(w_err);
        if (w_integ_raw > INTEG_MAX) begin
            w_integ_sat = INTEG_MAX;
        end else if (w_integ_raw < INTEG_MIN) begin
            w_integ_sat = INTEG_MIN;
        end else begin
            w_integ_sat = w_integ_raw;
        end
        n_terms.err   = w_err;
        n_terms.integ = w_integ_sat[psc_pkg::INTEG_W-1:0];
        n_terms.deriv = psc_pkg::DERIV_W'(w_err) - psc_pkg::DERIV_W'(r_last_err);
    end

    // loop state and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_integ    <= n_terms.integ;
                r_last_err <= w_err;
                r_valid    <= 1'b1;
            end else if (i_ready) begin
                r_valid    <= 1'b0;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_terms <= n_terms;
        end
    end

    assign o_valid = r_valid;
    assign o_terms = r_terms;

endmodule

FILE: design/psc_mult.sv
// Second stage: the three gain products, registered.
// Depends on psc_pkg.
module psc_mult (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  psc_pkg::t_terms i_terms,
    input  psc_pkg::t_gains i_gains,
    input  logic            i_ready,
    output logic            o_valid,
    output psc_pkg::t_prods o_prods
);

    logic            r_valid;
    psc_pkg::t_prods r_prods;
    psc_pkg::t_prods n_prods;
    logic            w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // signed products at full width
    always_comb begin
        n_prods.prod_prop  = i_gains.prop  * i_terms.err;
        n_prods.prod_integ = i_gains.integ * i_terms.integ;
        n_prods.prod_deriv = i_gains.deriv * i_terms.deriv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prods <= n_prods;
        end
    end

    assign o_valid = r_valid;
    assign o_prods = r_prods;

endmodule

FILE: design/psc_limit.sv
// Output stage: product sum, floor shift by 14, clamp to +/- one, result register.
// Depends on psc_pkg.
module psc_limit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  psc_pkg::t_prods                     i_prods,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic signed [psc_pkg::DRIVE_W-1:0]  o_drive,
    output logic                                o_clamped
);

    localparam logic signed [psc_pkg::SHIFT_W-1:0] OUT_MAX =
        psc_pkg::SHIFT_W'(psc_pkg::ONE_Q14);
    localparam logic signed [psc_pkg::SHIFT_W-1:0] OUT_MIN = -OUT_MAX;

    logic                                r_valid;
    logic signed [psc_pkg::DRIVE_W-1:0]  r_drive;
    logic                                r_clamped;

    logic                                w_accept;
    logic signed [psc_pkg::SUM_W-1:0]    w_sum;
    logic signed [psc_pkg::SHIFT_W-1:0]  w_shifted;
    logic signed [psc_pkg::DRIVE_W-1:0]  n_drive;
    logic                                n_clamped;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // sum, then floor shift (dropping the low bits of a signed word)
    always_comb begin
        w_sum = psc_pkg::SUM_W'(i_prods.prod_prop) + psc_pkg::SUM_W'(i_prods.prod_integ)
              + psc_pkg::SUM_W'(i_prods.prod_deriv);
        w_shifted = w_sum[psc_pkg::SUM_W-1:psc_pkg::OUT_SHIFT];
        if (w_shifted > OUT_MAX) begin
            n_drive   = OUT_MAX[psc_pkg::DRIVE_W-1:0];
            n_clamped = 1'b1;
        end else if (w_shifted < OUT_MIN) begin
            n_drive   = OUT_MIN[psc_pkg::DRIVE_W-1:0];
            n_clamped = 1'b1;
        end else begin
            n_drive   = w_shifted[psc_pkg::DRIVE_W-1:0];
            n_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    assign o_valid   = r_valid;
    assign o_drive   = r_drive;
    assign o_clamped = r_clamped;

endmodule
